// ----- sv/irpcr_pkg.sv -----
// Package for the infrared pulse capture and replay block.
// Holds the sizes, the function and mode codes, the request structs and the sequencer states.
// It depends on nothing else.
package irpcr_pkg;

  localparam int MAX_PAIRS = 24;
  localparam int NUM_SLOTS = 5;

  // Width of a pair count (0 to MAX_PAIRS) and of a capture buffer address.
  localparam int IDX_W = $clog2(MAX_PAIRS + 1);
  localparam int CAP_AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  // Address width of the slot store, which holds NUM_SLOTS rows of MAX_PAIRS pairs.
  localparam int SLOT_AW = $clog2(NUM_SLOTS * MAX_PAIRS);
  localparam int SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [7:0] COUNT_LIMIT_RESET = 8'd250;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_BUTTON = 2'd1;
  localparam logic [1:0] FUNC_SLOT   = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PAIR   = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LEARN  = 2'd1,
    MODE_STORE  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_PLAY_RD,
    ST_PLAY_OUT
  } seq_state_e;

  typedef struct packed {
    logic [1:0] func;
    logic       ir_level;
    logic [2:0] slot;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] mode;
    logic [7:0] on_count;
    logic [7:0] off_count;
    logic [4:0] captured_pairs;
    logic       last;
  } out_item_t;

endpackage

// ----- sv/ir_pulse_capture_replay.sv -----
// Top level of the infrared pulse capture and replay block.
// Holds the capture state machine, the capture buffer, the slot store and the copy/replay sequencer.
// Depends on irpcr_pkg.

// A learning infrared remote core. A request carries a function code: a sample
// tick with one receiver level per modulation period, a button event that
// toggles learn mode or cancels store mode, or a slot select. In learn mode a
// high sample starts a capture of on and off counts, each saturating at
// count_limit (0 acts as 1); an off count that reaches the limit ends the
// capture and the mode becomes store, while a capture that grows past
// MAX_PAIRS pairs is thrown away. In store mode a slot select copies the
// captured pairs into that slot; in normal mode it replays the slot as one
// result per stored pair, the final one flagged by last. Every other request
// gives one status result. Timing: a sample tick, a button event or an ignored
// request puts its status result in the output register on the next cycle. A
// store gives its status result at once and then copies the pairs one at a
// time through the capture buffer read (ST_COPY_RD) and the slot store write
// (ST_COPY_WR); the block takes no request until the copy is done. A replay
// passes each pair through the registered slot store read (ST_PLAY_RD) and
// the output register load (ST_PLAY_OUT), which a consumer stall holds. A
// request is taken only while the sequencer is idle and the output register
// is empty or being drained in the same cycle. count_limit is to be written
// through cfg_we_i only while the block is idle; the block does not enforce
// it. The stores hold no reset contents: only entries a capture wrote are read.
module ir_pulse_capture_replay (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  irpcr_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output irpcr_pkg::out_item_t out_data_o
);

  localparam int IDX_W = irpcr_pkg::IDX_W;
  localparam int CAP_AW = irpcr_pkg::CAP_AW;
  localparam int SLOT_AW = irpcr_pkg::SLOT_AW;
  localparam int SLOT_IW = irpcr_pkg::SLOT_IW;

  // Control and capture state.
  irpcr_pkg::seq_state_e state_q, state_d;
  irpcr_pkg::mode_e      mode_q, mode_d;
  logic [7:0]            limit_q;
  logic                  capturing_q, capturing_d;
  logic                  off_phase_q, off_phase_d;
  logic [7:0]            on_cnt_q, on_cnt_d;
  logic [7:0]            off_cnt_q, off_cnt_d;
  logic [IDX_W-1:0]      pair_idx_q, pair_idx_d;
  logic [IDX_W-1:0]      cap_len_q, cap_len_d;
  logic [IDX_W-1:0]      slot_len_q [irpcr_pkg::NUM_SLOTS];

  // Sequencer state for copy and replay.
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      run_len_q, run_len_d;
  logic [SLOT_AW-1:0]    base_q, base_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  irpcr_pkg::out_item_t  out_q, out_d;

  // Memories and their ports.
  logic [15:0]           cap_mem [irpcr_pkg::MAX_PAIRS];
  logic [15:0]           slot_mem [irpcr_pkg::NUM_SLOTS * irpcr_pkg::MAX_PAIRS];
  logic [15:0]           cap_rd_q;
  logic [15:0]           slot_rd_q;
  logic                  cap_we;
  logic [15:0]           cap_wdata;
  logic                  cap_re;
  logic                  slot_we;
  logic                  slot_re;
  logic [SLOT_AW-1:0]    slot_addr;

  logic                  slot_len_we;
  logic [SLOT_IW-1:0]    slot_sel;
  logic [IDX_W-1:0]      sel_len;
  logic                  slot_ok;
  logic                  accept;
  logic                  out_free;
  logic                  start_copy;
  logic                  start_play;
  logic                  play_last;
  logic [7:0]            lim;
  logic [7:0]            off_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign slot_sel = in_data_i.slot[SLOT_IW-1:0];
  assign slot_ok  = (32'(in_data_i.slot) < irpcr_pkg::NUM_SLOTS);
  assign sel_len  = slot_ok ? slot_len_q[slot_sel] : '0;
  assign lim      = (limit_q == 8'd0) ? 8'd1 : limit_q;
  assign off_inc  = (off_cnt_q < lim) ? off_cnt_q + 8'd1 : off_cnt_q;
  assign play_last = ((idx_q + IDX_W'(1)) == run_len_q);
  assign slot_addr = base_q + SLOT_AW'(idx_q);

  // Request decode, capture logic and result formation.
  always_comb begin
    mode_d      = mode_q;
    capturing_d = capturing_q;
    off_phase_d = off_phase_q;
    on_cnt_d    = on_cnt_q;
    off_cnt_d   = off_cnt_q;
    pair_idx_d  = pair_idx_q;
    cap_len_d   = cap_len_q;
    idx_d       = idx_q;
    run_len_d   = run_len_q;
    base_d      = base_q;
    cap_we      = 1'b0;
    cap_wdata   = {on_cnt_q, off_cnt_q};
    slot_len_we = 1'b0;
    start_copy  = 1'b0;
    start_play  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (accept) begin
      case (in_data_i.func)
        irpcr_pkg::FUNC_SAMPLE: begin
          if (mode_q == irpcr_pkg::MODE_LEARN) begin
            if (!capturing_q) begin
              if (in_data_i.ir_level) begin
                capturing_d = 1'b1;
                off_phase_d = 1'b0;
                on_cnt_d    = 8'd1;
                off_cnt_d   = 8'd0;
                pair_idx_d  = '0;
                cap_len_d   = '0;
              end
            end else if (!off_phase_q) begin
              if (in_data_i.ir_level) begin
                if (on_cnt_q < lim) on_cnt_d = on_cnt_q + 8'd1;
              end else begin
                off_phase_d = 1'b1;
                off_cnt_d   = 8'd1;
                if (lim == 8'd1) begin
                  cap_we      = 1'b1;
                  cap_wdata   = {on_cnt_q, 8'd1};
                  cap_len_d   = pair_idx_q + IDX_W'(1);
                  capturing_d = 1'b0;
                  mode_d      = irpcr_pkg::MODE_STORE;
                end
              end
            end else if (!in_data_i.ir_level) begin
              off_cnt_d = off_inc;
              if (off_inc >= lim) begin
                cap_we      = 1'b1;
                cap_wdata   = {on_cnt_q, off_inc};
                cap_len_d   = pair_idx_q + IDX_W'(1);
                capturing_d = 1'b0;
                mode_d      = irpcr_pkg::MODE_STORE;
              end
            end else begin
              // A high sample in the off phase completes the pair.
              cap_we = 1'b1;
              if (32'(pair_idx_q) + 1 >= irpcr_pkg::MAX_PAIRS) begin
                capturing_d = 1'b0;
                off_phase_d = 1'b0;
                on_cnt_d    = 8'd0;
                off_cnt_d   = 8'd0;
                pair_idx_d  = '0;
                cap_len_d   = '0;
              end else begin
                pair_idx_d  = pair_idx_q + IDX_W'(1);
                off_phase_d = 1'b0;
                on_cnt_d    = 8'd1;
                off_cnt_d   = 8'd0;
              end
            end
          end
        end
        irpcr_pkg::FUNC_BUTTON: begin
          if (mode_q == irpcr_pkg::MODE_NORMAL) begin
            mode_d = irpcr_pkg::MODE_LEARN;
          end else begin
            capturing_d = 1'b0;
            off_phase_d = 1'b0;
            mode_d      = irpcr_pkg::MODE_NORMAL;
          end
        end
        irpcr_pkg::FUNC_SLOT: begin
          if (slot_ok) begin
            base_d = SLOT_AW'(in_data_i.slot) * SLOT_AW'(irpcr_pkg::MAX_PAIRS);
            idx_d  = '0;
            if (mode_q == irpcr_pkg::MODE_STORE) begin
              slot_len_we = 1'b1;
              run_len_d   = cap_len_q;
              start_copy  = (cap_len_q != '0);
              mode_d      = irpcr_pkg::MODE_NORMAL;
            end else if (mode_q == irpcr_pkg::MODE_NORMAL) begin
              run_len_d  = sel_len;
              start_play = (sel_len != '0);
            end
          end
        end
        default: begin
        end
      endcase

      // Every request except a replay of a filled slot gives one status result.
      if (!start_play) begin
        out_valid_d          = 1'b1;
        out_d.kind           = irpcr_pkg::KIND_STATUS;
        out_d.mode           = mode_d;
        out_d.on_count       = 8'd0;
        out_d.off_count      = 8'd0;
        out_d.captured_pairs = 5'(cap_len_d);
        out_d.last           = 1'b1;
      end
    end

    case (state_q)
      irpcr_pkg::ST_COPY_WR: begin
        idx_d = idx_q + IDX_W'(1);
      end
      irpcr_pkg::ST_PLAY_OUT: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.kind           = irpcr_pkg::KIND_PAIR;
          out_d.mode           = mode_q;
          out_d.on_count       = slot_rd_q[15:8];
          out_d.off_count      = slot_rd_q[7:0];
          out_d.captured_pairs = 5'(cap_len_q);
          out_d.last           = play_last;
          idx_d                = idx_q + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      irpcr_pkg::ST_IDLE: begin
        if (start_copy) begin
          state_d = irpcr_pkg::ST_COPY_RD;
        end else if (start_play) begin
          state_d = irpcr_pkg::ST_PLAY_RD;
        end
      end
      irpcr_pkg::ST_COPY_RD: state_d = irpcr_pkg::ST_COPY_WR;
      irpcr_pkg::ST_COPY_WR: begin
        state_d = play_last ? irpcr_pkg::ST_IDLE : irpcr_pkg::ST_COPY_RD;
      end
      irpcr_pkg::ST_PLAY_RD: state_d = irpcr_pkg::ST_PLAY_OUT;
      irpcr_pkg::ST_PLAY_OUT: begin
        if (out_free) begin
          state_d = play_last ? irpcr_pkg::ST_IDLE : irpcr_pkg::ST_PLAY_RD;
        end
      end
      default: state_d = irpcr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == irpcr_pkg::ST_IDLE) && out_free;
    cap_re     = (state_q == irpcr_pkg::ST_COPY_RD);
    slot_we    = (state_q == irpcr_pkg::ST_COPY_WR);
    slot_re    = (state_q == irpcr_pkg::ST_PLAY_RD);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irpcr_pkg::ST_IDLE;
      mode_q      <= irpcr_pkg::MODE_NORMAL;
      limit_q     <= irpcr_pkg::COUNT_LIMIT_RESET;
      capturing_q <= 1'b0;
      off_phase_q <= 1'b0;
      on_cnt_q    <= 8'd0;
      off_cnt_q   <= 8'd0;
      pair_idx_q  <= '0;
      cap_len_q   <= '0;
      idx_q       <= '0;
      run_len_q   <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < irpcr_pkg::NUM_SLOTS; i++) begin
        slot_len_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      capturing_q <= capturing_d;
      off_phase_q <= off_phase_d;
      on_cnt_q    <= on_cnt_d;
      off_cnt_q   <= off_cnt_d;
      pair_idx_q  <= pair_idx_d;
      cap_len_q   <= cap_len_d;
      idx_q       <= idx_d;
      run_len_q   <= run_len_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (slot_len_we) begin
        slot_len_q[slot_sel] <= cap_len_q;
      end
    end
  end

  // The result payload needs no reset; out_valid_q qualifies it.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Capture buffer: written at the current pair, read in order during a copy.
  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      cap_mem[pair_idx_q[CAP_AW-1:0]] <= cap_wdata;
    end
    if (cap_re) begin
      cap_rd_q <= cap_mem[idx_q[CAP_AW-1:0]];
    end
  end

  // Slot store: one row of MAX_PAIRS pairs for each slot.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_addr] <= cap_rd_q;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_addr];
    end
  end

endmodule
